// ===== rtl/core/c2s_pkg.sv =====
// Shared constants, tables and width helpers for the cartesian-to-spherical
// angle core. No dependencies.
package c2s_pkg;

  localparam int DEFAULT_COORD_WIDTH = 24;
  localparam int DEFAULT_ANGLE_WIDTH = 16;
  localparam int DEFAULT_ITERATIONS  = 16;

  // distance field
  localparam int                DIST_W   = 25;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // angle magnitudes are scaled down until they fit this many bits
  localparam int PRESCALE_BITS = 30;

  // angle accumulator: pi is 2^31, needs headroom past +-pi
  localparam int ZW         = 33;
  localparam int ATAN_DEPTH = 24;

  localparam logic signed [ZW-1:0] HALF_PI_UNITS = ZW'(2**30);

  localparam logic [31:0] ATAN_UNITS [ATAN_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // width of a coordinate difference
  function automatic int mag_width(input int cw);
    return cw + 1;
  endfunction

  // width of a prescaled magnitude on the angle path
  function automatic int ang_mag_width(input int cw);
    return (cw + 1 > PRESCALE_BITS) ? PRESCALE_BITS : cw + 1;
  endfunction

  // root width shared by the distance and horizontal-length square roots
  function automatic int root_width(input int cw);
    int a;
    a = ang_mag_width(cw) + 1;
    return (a > DIST_W + 1) ? a : DIST_W + 1;
  endfunction

endpackage

// ===== rtl/core/c2s_in_if.sv =====
// Input channel of the angle core: a pair of 3D points with valid/ready.
// Depends on c2s_pkg.
interface c2s_in_if import c2s_pkg::*; #(
  parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH
) ();

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] from_x;
  logic signed [COORD_WIDTH-1:0] from_y;
  logic signed [COORD_WIDTH-1:0] from_z;
  logic signed [COORD_WIDTH-1:0] to_x;
  logic signed [COORD_WIDTH-1:0] to_y;
  logic signed [COORD_WIDTH-1:0] to_z;

  modport source (output valid, from_x, from_y, from_z, to_x, to_y, to_z, input ready);
  modport sink   (input valid, from_x, from_y, from_z, to_x, to_y, to_z, output ready);

endinterface

// ===== rtl/core/c2s_out_if.sv =====
// Result channel of the angle core: yaw, pitch and distance with valid/ready.
// Depends on c2s_pkg.
interface c2s_out_if import c2s_pkg::*; #(
  parameter int ANGLE_WIDTH = DEFAULT_ANGLE_WIDTH
) ();

  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] yaw;
  logic signed [ANGLE_WIDTH-1:0] pitch;
  logic        [DIST_W-1:0]      distance;

  modport source (output valid, yaw, pitch, distance, input ready);
  modport sink   (input valid, yaw, pitch, distance, output ready);

endinterface

// ===== rtl/core/c2s_front.sv =====
// Front end: differences, magnitudes, prescale, squares and sums of squares.
// Four register stages. Depends on c2s_pkg.
module c2s_front import c2s_pkg::*; #(
  parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         en_i,
  input  logic                                         valid_i,
  input  logic signed [COORD_WIDTH-1:0]                from_x_i,
  input  logic signed [COORD_WIDTH-1:0]                from_y_i,
  input  logic signed [COORD_WIDTH-1:0]                from_z_i,
  input  logic signed [COORD_WIDTH-1:0]                to_x_i,
  input  logic signed [COORD_WIDTH-1:0]                to_y_i,
  input  logic signed [COORD_WIDTH-1:0]                to_z_i,
  output logic                                         valid_o,
  output logic        [2*root_width(COORD_WIDTH)-1:0]  dsum_o,
  output logic        [2*root_width(COORD_WIDTH)-1:0]  hsum_o,
  output logic signed [ang_mag_width(COORD_WIDTH):0]   ax_o,
  output logic signed [ang_mag_width(COORD_WIDTH):0]   ay_o,
  output logic signed [ang_mag_width(COORD_WIDTH):0]   az_o,
  output logic                                         sat_o
);

  localparam int MAG_W  = mag_width(COORD_WIDTH);
  localparam int AMW    = ang_mag_width(COORD_WIDTH);
  localparam int NW     = 2 * root_width(COORD_WIDTH);
  localparam int ME_W   = (MAG_W > DIST_W) ? MAG_W : DIST_W;
  localparam int SH_MAX = (MAG_W > PRESCALE_BITS) ? MAG_W - PRESCALE_BITS : 0;
  localparam int SHW    = (SH_MAX > 0) ? $clog2(SH_MAX + 1) : 1;

  logic [3:0] v_q;

  // stage 0: differences
  logic signed [MAG_W-1:0] d_q [3];

  // stage 1 logic
  logic [MAG_W-1:0]        mg   [3];
  logic [ME_W-1:0]         mext [3];
  logic [DIST_W-1:0]       dmag [3];
  logic [AMW-1:0]          am   [3];
  logic signed [AMW:0]     a    [3];
  logic [MAG_W-1:0]        big;
  logic [SHW-1:0]          sh;
  logic                    sat;

  // stage 1..3 registers
  logic [DIST_W-1:0]       dmag_q [3];
  logic [AMW-1:0]          am_q   [2];
  logic signed [AMW:0]     a1_q   [3];
  logic signed [AMW:0]     a2_q   [3];
  logic signed [AMW:0]     a3_q   [3];
  logic                    sat1_q, sat2_q, sat3_q;
  logic [2*DIST_W-1:0]     dsq_q  [3];
  logic [2*AMW-1:0]        hsq_q  [2];
  logic [NW-1:0]           dsum_q, hsum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_comb begin
    sat = 1'b0;
    big = '0;
    sh  = '0;
    for (int k = 0; k < 3; k++) begin
      mg[k]   = d_q[k][MAG_W-1] ? MAG_W'(-d_q[k]) : MAG_W'(d_q[k]);
      mext[k] = ME_W'(mg[k]);
      if (mext[k] >= ME_W'(DIST_MAX)) begin
        sat = 1'b1;
      end
      dmag[k] = mext[k][DIST_W-1:0];
      if (mg[k] > big) begin
        big = mg[k];
      end
    end
    // smallest common shift that brings every magnitude under the prescale limit
    for (int s = SH_MAX; s >= 0; s--) begin
      if ((big >> (s + PRESCALE_BITS)) == '0) begin
        sh = SHW'(s);
      end
    end
    for (int k = 0; k < 3; k++) begin
      am[k] = AMW'(mg[k] >> sh);
      a[k]  = d_q[k][MAG_W-1] ? -$signed({1'b0, am[k]}) : $signed({1'b0, am[k]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0] <= MAG_W'(to_x_i) - MAG_W'(from_x_i);
      d_q[1] <= MAG_W'(to_y_i) - MAG_W'(from_y_i);
      d_q[2] <= MAG_W'(to_z_i) - MAG_W'(from_z_i);

      dmag_q <= dmag;
      am_q[0] <= am[0];
      am_q[1] <= am[1];
      a1_q   <= a;
      sat1_q <= sat;

      for (int k = 0; k < 3; k++) begin
        dsq_q[k] <= (2*DIST_W)'(dmag_q[k]) * (2*DIST_W)'(dmag_q[k]);
      end
      for (int k = 0; k < 2; k++) begin
        hsq_q[k] <= (2*AMW)'(am_q[k]) * (2*AMW)'(am_q[k]);
      end
      a2_q   <= a1_q;
      sat2_q <= sat1_q;

      dsum_q <= NW'(dsq_q[0]) + NW'(dsq_q[1]) + NW'(dsq_q[2]);
      hsum_q <= NW'(hsq_q[0]) + NW'(hsq_q[1]);
      a3_q   <= a2_q;
      sat3_q <= sat2_q;
    end
  end

  assign valid_o = v_q[3];
  assign dsum_o  = dsum_q;
  assign hsum_o  = hsum_q;
  assign ax_o    = a3_q[0];
  assign ay_o    = a3_q[1];
  assign az_o    = a3_q[2];
  assign sat_o   = sat3_q;

endmodule

// ===== rtl/core/c2s_sqrt_cell.sv =====
// One digit cell of the bit-serial square root chain, two radicands side by
// side, plus a carried side vector. Depends on c2s_pkg.
module c2s_sqrt_cell import c2s_pkg::*; #(
  parameter int ROOT_W = root_width(DEFAULT_COORD_WIDTH),
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [2*ROOT_W-1:0]   rad_a_i,
  input  logic [2*ROOT_W-1:0]   root_a_i,
  input  logic [2*ROOT_W-1:0]   rad_b_i,
  input  logic [2*ROOT_W-1:0]   root_b_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [2*ROOT_W-1:0]   rad_a_o,
  output logic [2*ROOT_W-1:0]   root_a_o,
  output logic [2*ROOT_W-1:0]   rad_b_o,
  output logic [2*ROOT_W-1:0]   root_b_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int          NW  = 2 * ROOT_W;
  localparam logic [NW:0] BIT = (NW+1)'(1) << (2 * STEP);

  // returns {radicand, root} after one digit
  function automatic logic [2*NW-1:0] digit(input logic [NW-1:0] rad,
                                            input logic [NW-1:0] root);
    logic [NW:0] trial;
    trial = {1'b0, root} + BIT;
    if ({1'b0, rad} >= trial) begin
      return {rad - trial[NW-1:0], (root >> 1) + BIT[NW-1:0]};
    end
    return {rad, root >> 1};
  endfunction

  logic [2*NW-1:0] step_a, step_b;
  logic            valid_q;
  logic [NW-1:0]   rad_a_q, root_a_q, rad_b_q, root_b_q;
  logic [SIDE_W-1:0] side_q;

  assign step_a = digit(rad_a_i, root_a_i);
  assign step_b = digit(rad_b_i, root_b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_a_q  <= step_a[2*NW-1:NW];
      root_a_q <= step_a[NW-1:0];
      rad_b_q  <= step_b[2*NW-1:NW];
      root_b_q <= step_b[NW-1:0];
      side_q   <= side_i;
    end
  end

  assign valid_o  = valid_q;
  assign rad_a_o  = rad_a_q;
  assign root_a_o = root_a_q;
  assign rad_b_o  = rad_b_q;
  assign root_b_o = root_b_q;
  assign side_o   = side_q;

endmodule

// ===== rtl/core/c2s_cordic_cell.sv =====
// One vectoring CORDIC micro-rotation for the yaw and pitch lanes, with a
// carried side vector. Depends on c2s_pkg (arctangent table, ZW).
module c2s_cordic_cell import c2s_pkg::*; #(
  parameter int XW     = ang_mag_width(DEFAULT_COORD_WIDTH) + 3,
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [XW-1:0]  yx_i,
  input  logic signed [XW-1:0]  yy_i,
  input  logic signed [ZW-1:0]  yz_i,
  input  logic signed [XW-1:0]  px_i,
  input  logic signed [XW-1:0]  py_i,
  input  logic signed [ZW-1:0]  pz_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic signed [XW-1:0]  yx_o,
  output logic signed [XW-1:0]  yy_o,
  output logic signed [ZW-1:0]  yz_o,
  output logic signed [XW-1:0]  px_o,
  output logic signed [XW-1:0]  py_o,
  output logic signed [ZW-1:0]  pz_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int                   RW   = 2 * XW + ZW;
  localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN_UNITS[STEP]);

  // returns {x, y, z}; rotate toward y = 0
  function automatic logic [RW-1:0] rotate(input logic signed [XW-1:0] x,
                                           input logic signed [XW-1:0] y,
                                           input logic signed [ZW-1:0] z);
    logic signed [XW-1:0] xs, ys;
    xs = x >>> STEP;
    ys = y >>> STEP;
    if (!y[XW-1]) begin
      return {x + ys, y - xs, z + ATAN};
    end
    return {x - ys, y + xs, z - ATAN};
  endfunction

  logic [RW-1:0]        rot_y, rot_p;
  logic                 valid_q;
  logic signed [XW-1:0] yx_q, yy_q, px_q, py_q;
  logic signed [ZW-1:0] yz_q, pz_q;
  logic [SIDE_W-1:0]    side_q;

  assign rot_y = rotate(yx_i, yy_i, yz_i);
  assign rot_p = rotate(px_i, py_i, pz_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yx_q   <= rot_y[RW-1 -: XW];
      yy_q   <= rot_y[ZW+XW-1 -: XW];
      yz_q   <= rot_y[ZW-1:0];
      px_q   <= rot_p[RW-1 -: XW];
      py_q   <= rot_p[ZW+XW-1 -: XW];
      pz_q   <= rot_p[ZW-1:0];
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign yx_o    = yx_q;
  assign yy_o    = yy_q;
  assign yz_o    = yz_q;
  assign px_o    = px_q;
  assign py_o    = py_q;
  assign pz_o    = pz_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/core/cartesian_to_spherical_angles_core.sv =====
// Top level of the cartesian-to-spherical angle core: front end, square root
// chain, CORDIC chain and result register. Depends on c2s_pkg, c2s_in_if,
// c2s_out_if, c2s_front, c2s_sqrt_cell and c2s_cordic_cell.
//
// Takes one point pair per clock and returns, for d = to - from, the yaw
// atan2(dx, dy), the pitch atan2(-dz, horizontal length), both as binary
// angles with 2^ANGLE_WIDTH to a full turn, and the saturating Euclidean
// length. The block is a fully pipelined chain: four front-end stages
// (differences, magnitudes with common prescale, squares, sums), one square
// root cell per result bit (root_width(COORD_WIDTH) cells, 26 by default),
// one setup stage, one CORDIC cell per iteration and the result register.
// Throughput is one item per cycle. The whole chain advances together and
// holds while a result waits at the output and the sink is not ready.
module cartesian_to_spherical_angles_core import c2s_pkg::*; #(
  parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH,
  parameter int ANGLE_WIDTH = DEFAULT_ANGLE_WIDTH,
  parameter int ITERATIONS  = DEFAULT_ITERATIONS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  c2s_in_if.sink    pt_i,
  c2s_out_if.source res_o
);

  localparam int AMW       = ang_mag_width(COORD_WIDTH);
  localparam int ROOT_W    = root_width(COORD_WIDTH);
  localparam int NW        = 2 * ROOT_W;
  localparam int XW        = AMW + 3;
  localparam int SQ_SIDE_W = 1 + 3 * (AMW + 1);
  localparam int CR_SIDE_W = 2 + DIST_W;
  localparam int SH        = 32 - ANGLE_WIDTH;

  localparam logic signed [ZW-1:0] ROUND   = ZW'(1) << (SH - 1);
  localparam logic signed [ZW-1:0] QUARTER = ZW'(1) << (ANGLE_WIDTH - 2);

  logic en;

  // front end
  logic                f_valid;
  logic [NW-1:0]       f_dsum, f_hsum;
  logic signed [AMW:0] f_ax, f_ay, f_az;
  logic                f_sat;

  // square root chain
  logic                 sq_valid  [ROOT_W+1];
  logic [NW-1:0]        sq_rad_a  [ROOT_W+1];
  logic [NW-1:0]        sq_root_a [ROOT_W+1];
  logic [NW-1:0]        sq_rad_b  [ROOT_W+1];
  logic [NW-1:0]        sq_root_b [ROOT_W+1];
  logic [SQ_SIDE_W-1:0] sq_side   [ROOT_W+1];

  // setup stage
  logic signed [AMW:0]  s_ax, s_ay, s_az;
  logic                 s_sat;
  logic [AMW:0]         s_h;
  logic [ROOT_W-1:0]    s_root;
  logic signed [XW-1:0] s_yx, s_yy, s_x0, s_y0, s_px, s_py;
  logic signed [ZW-1:0] s_z0;
  logic [DIST_W-1:0]    s_dist;
  logic                 s_yaw_zero, s_pitch_zero;

  logic                 setup_valid_q;
  logic signed [XW-1:0] setup_yx_q, setup_yy_q, setup_px_q, setup_py_q;
  logic signed [ZW-1:0] setup_yz_q;
  logic [CR_SIDE_W-1:0] setup_side_q;

  // CORDIC chain
  logic                 cr_valid [ITERATIONS+1];
  logic signed [XW-1:0] cr_yx    [ITERATIONS+1];
  logic signed [XW-1:0] cr_yy    [ITERATIONS+1];
  logic signed [ZW-1:0] cr_yz    [ITERATIONS+1];
  logic signed [XW-1:0] cr_px    [ITERATIONS+1];
  logic signed [XW-1:0] cr_py    [ITERATIONS+1];
  logic signed [ZW-1:0] cr_pz    [ITERATIONS+1];
  logic [CR_SIDE_W-1:0] cr_side  [ITERATIONS+1];

  // result stage
  logic signed [ZW-1:0]          o_yaw_full, o_pitch_full, o_pitch_clamp;
  logic signed [ANGLE_WIDTH-1:0] o_yaw, o_pitch;

  logic                          res_valid_q;
  logic signed [ANGLE_WIDTH-1:0] res_yaw_q, res_pitch_q;
  logic [DIST_W-1:0]             res_dist_q;

  assign en         = !res_valid_q || res_o.ready;
  assign pt_i.ready = en;

  c2s_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (pt_i.valid),
    .from_x_i (pt_i.from_x),
    .from_y_i (pt_i.from_y),
    .from_z_i (pt_i.from_z),
    .to_x_i   (pt_i.to_x),
    .to_y_i   (pt_i.to_y),
    .to_z_i   (pt_i.to_z),
    .valid_o  (f_valid),
    .dsum_o   (f_dsum),
    .hsum_o   (f_hsum),
    .ax_o     (f_ax),
    .ay_o     (f_ay),
    .az_o     (f_az),
    .sat_o    (f_sat)
  );

  // lane a: full distance, lane b: horizontal length
  assign sq_valid[0]  = f_valid;
  assign sq_rad_a[0]  = f_dsum;
  assign sq_root_a[0] = '0;
  assign sq_rad_b[0]  = f_hsum;
  assign sq_root_b[0] = '0;
  assign sq_side[0]   = {f_sat, f_az, f_ay, f_ax};

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
    c2s_sqrt_cell #(
      .ROOT_W (ROOT_W),
      .STEP   (ROOT_W - 1 - g),
      .SIDE_W (SQ_SIDE_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (sq_valid[g]),
      .rad_a_i  (sq_rad_a[g]),
      .root_a_i (sq_root_a[g]),
      .rad_b_i  (sq_rad_b[g]),
      .root_b_i (sq_root_b[g]),
      .side_i   (sq_side[g]),
      .valid_o  (sq_valid[g+1]),
      .rad_a_o  (sq_rad_a[g+1]),
      .root_a_o (sq_root_a[g+1]),
      .rad_b_o  (sq_rad_b[g+1]),
      .root_b_o (sq_root_b[g+1]),
      .side_o   (sq_side[g+1])
    );
  end

  assign s_ax   = $signed(sq_side[ROOT_W][AMW:0]);
  assign s_ay   = $signed(sq_side[ROOT_W][2*(AMW+1)-1 -: AMW+1]);
  assign s_az   = $signed(sq_side[ROOT_W][3*(AMW+1)-1 -: AMW+1]);
  assign s_sat  = sq_side[ROOT_W][SQ_SIDE_W-1];
  assign s_h    = sq_root_b[ROOT_W][AMW:0];
  assign s_root = sq_root_a[ROOT_W][ROOT_W-1:0];

  always_comb begin
    // yaw is atan2(dx, dy): x input is dy, y input is dx
    s_yx = XW'(s_ay);
    s_yy = XW'(s_ax);
    s_x0 = s_yx;
    s_y0 = s_yy;
    s_z0 = '0;
    // left half plane: pre-rotate by a quarter turn
    if (s_yx[XW-1]) begin
      if (!s_yy[XW-1]) begin
        s_x0 = s_yy;
        s_y0 = -s_yx;
        s_z0 = HALF_PI_UNITS;
      end else begin
        s_x0 = -s_yy;
        s_y0 = s_yx;
        s_z0 = -HALF_PI_UNITS;
      end
    end
    s_px = $signed(XW'(s_h));
    s_py = -XW'(s_az);
    s_yaw_zero   = (s_ax == '0) && (s_ay == '0);
    s_pitch_zero = (s_az == '0) && (s_h == '0);
    s_dist = (s_sat || (s_root > ROOT_W'(DIST_MAX))) ? DIST_MAX : s_root[DIST_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_valid_q <= 1'b0;
      res_valid_q   <= 1'b0;
    end else if (en) begin
      setup_valid_q <= sq_valid[ROOT_W];
      res_valid_q   <= cr_valid[ITERATIONS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      setup_yx_q   <= s_x0;
      setup_yy_q   <= s_y0;
      setup_yz_q   <= s_z0;
      setup_px_q   <= s_px;
      setup_py_q   <= s_py;
      setup_side_q <= {s_yaw_zero, s_pitch_zero, s_dist};
    end
  end

  assign cr_valid[0] = setup_valid_q;
  assign cr_yx[0]    = setup_yx_q;
  assign cr_yy[0]    = setup_yy_q;
  assign cr_yz[0]    = setup_yz_q;
  assign cr_px[0]    = setup_px_q;
  assign cr_py[0]    = setup_py_q;
  assign cr_pz[0]    = '0;
  assign cr_side[0]  = setup_side_q;

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_cordic
    c2s_cordic_cell #(
      .XW     (XW),
      .STEP   (g),
      .SIDE_W (CR_SIDE_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cr_valid[g]),
      .yx_i    (cr_yx[g]),
      .yy_i    (cr_yy[g]),
      .yz_i    (cr_yz[g]),
      .px_i    (cr_px[g]),
      .py_i    (cr_py[g]),
      .pz_i    (cr_pz[g]),
      .side_i  (cr_side[g]),
      .valid_o (cr_valid[g+1]),
      .yx_o    (cr_yx[g+1]),
      .yy_o    (cr_yy[g+1]),
      .yz_o    (cr_yz[g+1]),
      .px_o    (cr_px[g+1]),
      .py_o    (cr_py[g+1]),
      .pz_o    (cr_pz[g+1]),
      .side_o  (cr_side[g+1])
    );
  end

  always_comb begin
    // round to nearest output LSB, floor shift
    o_yaw_full   = (cr_yz[ITERATIONS] + ROUND) >>> SH;
    o_pitch_full = (cr_pz[ITERATIONS] + ROUND) >>> SH;
    o_pitch_clamp = o_pitch_full;
    if (o_pitch_full > QUARTER) begin
      o_pitch_clamp = QUARTER;
    end else if (o_pitch_full < -QUARTER) begin
      o_pitch_clamp = -QUARTER;
    end
    // yaw at pi wraps to the most negative code here
    o_yaw   = cr_side[ITERATIONS][CR_SIDE_W-1] ? '0 : o_yaw_full[ANGLE_WIDTH-1:0];
    o_pitch = cr_side[ITERATIONS][CR_SIDE_W-2] ? '0 : o_pitch_clamp[ANGLE_WIDTH-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_yaw_q   <= o_yaw;
      res_pitch_q <= o_pitch;
      res_dist_q  <= cr_side[ITERATIONS][DIST_W-1:0];
    end
  end

  assign res_o.valid    = res_valid_q;
  assign res_o.yaw      = res_yaw_q;
  assign res_o.pitch    = res_pitch_q;
  assign res_o.distance = res_dist_q;

endmodule

// ===== sim/c2s_angle_checker.sv =====
// Checker for the cartesian-to-spherical angle core: watches both channels,
// predicts yaw, pitch and distance per accepted item and compares in order.
// Depends on c2s_pkg, c2s_in_if and c2s_out_if.
module c2s_angle_checker import c2s_pkg::*; #(
  parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH,
  parameter int ANGLE_WIDTH = DEFAULT_ANGLE_WIDTH,
  parameter int ITERATIONS  = DEFAULT_ITERATIONS
) (
  input  logic clk_i,
  input  logic rst_ni,
  c2s_in_if    pt_mon,
  c2s_out_if   res_mon,
  output int   errors_o,
  output int   pending_o
);

  typedef struct packed {
    logic [ANGLE_WIDTH-1:0] yaw;
    logic [ANGLE_WIDTH-1:0] pitch;
    logic [DIST_W-1:0]      distance;
  } angles_t;

  // arctan(2^-i), pi = 2^31
  localparam longint ARCTAN_Q31 [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };
  localparam longint QUARTER_TURN = 64'sd1073741824;

  angles_t expected_angles_q [$];
  int      fail_count;

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= root + probe) begin
        n    = n - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // vectoring CORDIC, result in units where pi = 2^31
  function automatic longint vector_angle(input longint y, input longint x);
    longint z;
    longint t;
    longint xs;
    longint ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      // fold into the right half plane first
      if (y >= 0) begin
        t = x; x = y;  y = -t; z = QUARTER_TURN;
      end else begin
        t = x; x = -y; y = t;  z = -QUARTER_TURN;
      end
    end
    for (int i = 0; i < ITERATIONS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + ARCTAN_Q31[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ARCTAN_Q31[i];
      end
    end
    return z;
  endfunction

  function automatic longint to_binary_angle(input longint z);
    int sh;
    sh = 32 - ANGLE_WIDTH;
    return (z + (longint'(1) <<< (sh - 1))) >>> sh;
  endfunction

  function automatic angles_t predict_angles(input longint dx, input longint dy,
                                             input longint dz);
    longint unsigned mx, my, mz, big, dmax, dist_len;
    longint          ax, ay, az, h, yaw_ang, pitch_ang, q;
    int              s;
    angles_t         r;
    dmax = (longint'(1) << DIST_W) - 1;
    mx   = (dx < 0) ? -dx : dx;
    my   = (dy < 0) ? -dy : dy;
    mz   = (dz < 0) ? -dz : dz;
    if (mx >= dmax || my >= dmax || mz >= dmax) begin
      dist_len = dmax;
    end else begin
      dist_len = int_sqrt(mx * mx + my * my + mz * mz);
      if (dist_len > dmax) dist_len = dmax;
    end
    // common prescale so every magnitude fits the angle path
    big = (mx > my) ? mx : my;
    if (mz > big) big = mz;
    s = 0;
    while ((big >> s) >= (longint'(1) << PRESCALE_BITS)) s++;
    ax = longint'(mx >> s); if (dx < 0) ax = -ax;
    ay = longint'(my >> s); if (dy < 0) ay = -ay;
    az = longint'(mz >> s); if (dz < 0) az = -az;
    yaw_ang   = to_binary_angle(vector_angle(ax, ay));
    h         = longint'(int_sqrt(longint'(ax * ax) + longint'(ay * ay)));
    pitch_ang = to_binary_angle(vector_angle(-az, h));
    q         = longint'(1) << (ANGLE_WIDTH - 2);
    if (pitch_ang > q)  pitch_ang = q;
    if (pitch_ang < -q) pitch_ang = -q;
    r.yaw      = yaw_ang[ANGLE_WIDTH-1:0];
    r.pitch    = pitch_ang[ANGLE_WIDTH-1:0];
    r.distance = dist_len[DIST_W-1:0];
    return r;
  endfunction

  initial begin
    fail_count = 0;
    errors_o   = 0;
    pending_o  = 0;
  end

  always @(posedge clk_i) begin
    angles_t want;
    angles_t got;
    if (rst_ni) begin
      if (pt_mon.valid && pt_mon.ready) begin
        expected_angles_q.push_back(predict_angles(
          longint'(pt_mon.to_x) - longint'(pt_mon.from_x),
          longint'(pt_mon.to_y) - longint'(pt_mon.from_y),
          longint'(pt_mon.to_z) - longint'(pt_mon.from_z)));
      end
      if (res_mon.valid && res_mon.ready) begin
        got.yaw      = res_mon.yaw;
        got.pitch    = res_mon.pitch;
        got.distance = res_mon.distance;
        if (expected_angles_q.size() == 0) begin
          $error("result item with nothing predicted: yaw %0d pitch %0d distance %0d",
                 $signed(got.yaw), $signed(got.pitch), got.distance);
          fail_count++;
        end else begin
          want = expected_angles_q.pop_front();
          if (got.yaw !== want.yaw) begin
            $error("yaw: expected %0d, got %0d", $signed(want.yaw), $signed(got.yaw));
            fail_count++;
          end
          if (got.pitch !== want.pitch) begin
            $error("pitch: expected %0d, got %0d", $signed(want.pitch), $signed(got.pitch));
            fail_count++;
          end
          if (got.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, got.distance);
            fail_count++;
          end
        end
      end
      errors_o  = fail_count;
      pending_o = expected_angles_q.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the cartesian-to-spherical angle core: clock, reset,
// point-pair stimulus, random result back-pressure, watchdog and verdict.
// Depends on c2s_pkg, both channel interfaces, the core and c2s_angle_checker.
module tb_top;
  import c2s_pkg::*;

  localparam int CW           = DEFAULT_COORD_WIDTH;
  localparam int AW           = DEFAULT_ANGLE_WIDTH;
  localparam int ITER         = DEFAULT_ITERATIONS;
  localparam int LATENCY      = root_width(CW) + ITER + 6;
  localparam int CMAX         = (1 << (CW - 1)) - 1;
  localparam int CMIN         = -(1 << (CW - 1));
  localparam int RANDOM_ITEMS = 700;
  localparam int IDLE_LIMIT   = 3000;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  int   burst_left;

  c2s_in_if  #(.COORD_WIDTH(CW)) pt_if  ();
  c2s_out_if #(.ANGLE_WIDTH(AW)) res_if ();

  cartesian_to_spherical_angles_core #(
    .COORD_WIDTH(CW),
    .ANGLE_WIDTH(AW),
    .ITERATIONS (ITER)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pt_i  (pt_if),
    .res_o (res_if)
  );

  c2s_angle_checker #(
    .COORD_WIDTH(CW),
    .ANGLE_WIDTH(AW),
    .ITERATIONS (ITER)
  ) u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pt_mon   (pt_if),
    .res_mon  (res_if),
    .errors_o (errors),
    .pending_o(pending)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic int rand_coord();
    logic signed [CW-1:0] v;
    v = CW'($urandom);
    return int'(v);
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(0, 5))
      0:       return CMIN;
      1:       return CMAX;
      2:       return 0;
      3:       return 1;
      4:       return -1;
      default: return CMIN + 1;
    endcase
  endfunction

  function automatic int near(input int base, input int w);
    int m;
    int v;
    m = 1 << w;
    v = base + (int'($urandom_range(0, 2 * m)) - m);
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v;
  endfunction

  // entered and left at a falling edge
  task automatic send_pair(input int fx, input int fy, input int fz,
                           input int tx, input int ty, input int tz);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(20, 80);
    end
    repeat (gap) begin
      pt_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pt_if.valid  <= 1'b1;
    pt_if.from_x <= CW'(fx);
    pt_if.from_y <= CW'(fy);
    pt_if.from_z <= CW'(fz);
    pt_if.to_x   <= CW'(tx);
    pt_if.to_y   <= CW'(ty);
    pt_if.to_z   <= CW'(tz);
    do @(posedge clk_i); while (!pt_if.ready);
    @(negedge clk_i);
  endtask

  // result back-pressure
  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 99) < 30) begin
        repeat ($urandom_range(20, 150)) begin
          @(negedge clk_i);
          res_if.ready <= 1'b1;
        end
      end else begin
        repeat (pick_gap()) begin
          @(negedge clk_i);
          res_if.ready <= 1'b0;
        end
        repeat ($urandom_range(1, 4)) begin
          @(negedge clk_i);
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  // ends the run when nothing moves on either channel for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready)) idle = 0;
      else idle++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int kind;
    int sel;
    int fx, fy, fz, tx, ty, tz;
    rst_ni       = 1'b0;
    burst_left   = 0;
    pt_if.valid  = 1'b0;
    pt_if.from_x = '0;
    pt_if.from_y = '0;
    pt_if.from_z = '0;
    pt_if.to_x   = '0;
    pt_if.to_y   = '0;
    pt_if.to_z   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed items
    send_pair(0, 0, 0, 0, 0, 0);
    send_pair(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    send_pair(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    send_pair(1234, -567, 89, 1234, -567, 89);
    send_pair(0, 0, 0, 0, 100, 0);
    send_pair(0, 0, 0, 0, -100, 0);            // yaw at pi wraps
    send_pair(0, 0, 0, 100, 0, 0);
    send_pair(0, 0, 0, -100, 0, 0);
    send_pair(0, 0, 0, 300, -200, 0);          // negative x argument, both rotations
    send_pair(0, 0, 0, -300, -200, 0);
    send_pair(0, 0, 0, -300, 200, 0);
    send_pair(0, 0, 0, 0, 0, 500);             // straight down / up
    send_pair(0, 0, 0, 0, 0, -500);
    send_pair(0, 0, CMAX, 1, 0, CMIN);         // pitch near the pole
    send_pair(0, 0, CMIN, 0, 1, CMAX);
    send_pair(0, 0, 0, 1, 1, 1);
    send_pair(0, 0, 0, -1, -1, -1);
    send_pair(CMIN, 0, 0, CMAX, 0, 0);
    send_pair(0, CMAX, 0, 0, CMIN, 0);
    send_pair(0, 0, 0, 3, 4, 0);
    send_pair(10, 20, 30, 12, 23, 36);
    send_pair(CMAX, CMIN, 0, CMIN, CMAX, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(0, 99);
      fx = rand_coord(); fy = rand_coord(); fz = rand_coord();
      tx = rand_coord(); ty = rand_coord(); tz = rand_coord();
      if (kind < 35) begin
        // fully random
      end else if (kind < 60) begin
        tx = near(fx, $urandom_range(0, 16));
        ty = near(fy, $urandom_range(0, 16));
        tz = near(fz, $urandom_range(0, 16));
      end else if (kind < 75) begin
        // one or two components zero
        sel = $urandom_range(1, 6);
        if (sel[0]) tx = fx;
        if (sel[1]) ty = fy;
        if (sel[2]) tz = fz;
      end else if (kind < 88) begin
        fx = edge_coord(); fy = edge_coord(); fz = edge_coord();
        tx = edge_coord(); ty = edge_coord(); tz = edge_coord();
      end else begin
        // steep: vertical component dominates
        tx = near(fx, $urandom_range(0, 4));
        ty = near(fy, $urandom_range(0, 4));
      end
      send_pair(fx, fy, fz, tx, ty, tz);
    end
    pt_if.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== cartesian_to_spherical_angles_core.f =====
rtl/core/c2s_pkg.sv
rtl/core/c2s_in_if.sv
rtl/core/c2s_out_if.sv
rtl/core/c2s_front.sv
rtl/core/c2s_sqrt_cell.sv
rtl/core/c2s_cordic_cell.sv
rtl/core/cartesian_to_spherical_angles_core.sv
sim/c2s_angle_checker.sv
sim/tb_top.sv
